FILE: hdl/htl_pkg.sv
// ----------------------------------------------------------------------------
// htl_pkg
// types, character codes and the per-item event generator of the html lexer
// ----------------------------------------------------------------------------
package htl_pkg;

	localparam int MaxEvents = 4;
	localparam int CntW      = $clog2(MaxEvents + 1);
	localparam int IdxW      = $clog2(MaxEvents);

	localparam logic [7:0] ChLt     = 8'h3C;
	localparam logic [7:0] ChSlash  = 8'h2F;
	localparam logic [7:0] ChGt     = 8'h3E;
	localparam logic [7:0] ChEq     = 8'h3D;
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChNl     = 8'h0A;
	localparam logic [7:0] ChDquote = 8'h22;
	localparam logic [7:0] ChSquote = 8'h27;

	typedef enum logic [3:0] {
		EV_BREAK      = 4'd0,
		EV_SPACE      = 4'd1,
		EV_CHAR       = 4'd2,
		EV_OPEN_SLASH = 4'd3,
		EV_OPEN       = 4'd4,
		EV_CLOSE      = 4'd5,
		EV_EQUALS     = 4'd6,
		EV_SQUOTE     = 4'd7,
		EV_DQUOTE     = 4'd8,
		EV_TAGNAME    = 4'd9,
		EV_TEXT       = 4'd10
	} ev_kind_t;

	typedef struct packed {
		logic in_tag;
		logic in_quote;
		logic token_open;
		logic prev_space;
		logic pending_lt;
	} lex_state_t;

	typedef struct packed {
		ev_kind_t [MaxEvents-1:0]        kind;
		logic     [MaxEvents-1:0][7:0]   chr;
		logic     [CntW-1:0]             cnt;
		lex_state_t                      nxt;
	} lex_res_t;

	// append one event to the list while it has room
	function automatic lex_res_t ev_push(lex_res_t r, ev_kind_t k, logic [7:0] c);
		lex_res_t o;
		o = r;
		if (r.cnt < CntW'(MaxEvents)) begin
			o.kind[r.cnt[IdxW-1:0]] = k;
			o.chr[r.cnt[IdxW-1:0]]  = (k == EV_CHAR) ? c : 8'h00;
			o.cnt = r.cnt + CntW'(1);
		end
		return o;
	endfunction

	// close a token in progress with a break
	function automatic lex_res_t ev_flush(lex_res_t r);
		lex_res_t o;
		o = r;
		if (r.nxt.token_open) begin
			o = ev_push(o, EV_BREAK, 8'h00);
			o.nxt.token_open = 1'b0;
		end
		return o;
	endfunction

	// all events of one byte, and the state it leaves
	function automatic lex_res_t lex_step(lex_state_t st, logic [7:0] c_in, logic last);
		lex_res_t   r;
		logic [7:0] c;
		logic       handle;
		logic       is_q;
		r        = '0;
		r.nxt    = st;
		handle   = 1'b0;
		c        = (c_in == ChNl) ? ChSpace : c_in;
		is_q     = (c == ChSquote) || (c == ChDquote);
		if (!(c == ChSpace && st.prev_space)) begin
			r.nxt.prev_space = (c == ChSpace);
			if (st.pending_lt) begin
				r.nxt.pending_lt = 1'b0;
				r.nxt.in_tag     = 1'b1;
				r = ev_flush(r);
				if (c == ChSlash) begin
					r = ev_push(r, EV_OPEN_SLASH, 8'h00);
				end else begin
					r = ev_push(r, EV_OPEN, 8'h00);
					handle = 1'b1;
				end
			end else begin
				handle = 1'b1;
			end
		end
		if (handle) begin
			if (c == ChLt) begin
				r.nxt.pending_lt = 1'b1;
			end else if (c == ChGt) begin
				r.nxt.in_tag = 1'b0;
				r = ev_flush(r);
				r = ev_push(r, EV_CLOSE, 8'h00);
			end else if (c == ChEq) begin
				r = ev_flush(r);
				r = ev_push(r, EV_EQUALS, 8'h00);
			end else if (is_q && r.nxt.in_tag) begin
				r.nxt.in_tag   = 1'b0;
				r.nxt.in_quote = 1'b1;
				r = ev_flush(r);
				r = ev_push(r, (c == ChSquote) ? EV_SQUOTE : EV_DQUOTE, 8'h00);
			end else if (is_q && r.nxt.in_quote) begin
				r.nxt.in_tag   = 1'b1;
				r.nxt.in_quote = 1'b0;
			end else if (c == ChSpace) begin
				if (r.nxt.in_tag) begin
					r = ev_push(r, EV_BREAK, 8'h00);
					r.nxt.token_open = 1'b0;
				end else if (r.nxt.token_open) begin
					r = ev_push(r, EV_SPACE, 8'h00);
				end
			end else if (r.nxt.in_tag) begin
				if (!r.nxt.token_open) begin
					r.nxt.token_open = 1'b1;
					r = ev_push(r, EV_TAGNAME, 8'h00);
				end
				r = ev_push(r, EV_CHAR, c);
			end else begin
				if (r.nxt.in_quote) begin
					r.nxt.token_open = 1'b1;
				end else if (!r.nxt.token_open) begin
					r.nxt.token_open = 1'b1;
					r = ev_push(r, EV_TEXT, 8'h00);
				end
				r = ev_push(r, EV_CHAR, c);
			end
		end
		if (last) begin
			if (r.nxt.pending_lt) begin
				r.nxt.in_tag = 1'b1;
				r = ev_flush(r);
				r = ev_push(r, EV_OPEN, 8'h00);
			end
			r.nxt = '0;
		end
		return r;
	endfunction

endpackage

FILE: hdl/html_token_lexer_core.sv
// ----------------------------------------------------------------------------
// html_token_lexer_core
// streaming html lexer: one byte in, zero to four token events out
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ------------------------------------
//  input    in_valid / in_stall   char_in[7:0], end_of_text
//  output   out_valid / out_stall event_kind[3:0], char_out[7:0], last_of_run
//
//  a byte is registered on entry, then its events are worked out
//  combinationally and loaded into a four-entry event buffer; the buffer
//  drains one event a cycle while out_stall is low
//  items with no event leave the buffer empty
//  reset clears the lexer flags and all valid state; no clearing pass
//  output stall holds the buffer head; the input stage stalls only while
//  its byte waits for the buffer to empty
//
module html_token_lexer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] event_kind,
	output logic [7:0] char_out,
	output logic       last_of_run
);
	import htl_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// lexer flags, updated when an item's events are loaded
	lex_state_t state_q;

	// event buffer
	ev_kind_t [MaxEvents-1:0]      buf_kind_q;
	logic     [MaxEvents-1:0][7:0] buf_chr_q;
	logic     [CntW-1:0]           buf_cnt_q;
	logic     [IdxW-1:0]           buf_idx_q;

	lex_res_t res;
	logic     head_last;
	logic     take;
	logic     buf_free;
	logic     xfer;
	logic     in_take;

	// events of the byte held in the input stage
	assign res = lex_step(state_q, char_s1, last_s1);

	assign head_last = ({1'b0, buf_idx_q} + CntW'(1)) == buf_cnt_q;
	assign take      = out_valid && !out_stall;
	// buffer can be refilled when empty or its last event leaves now
	assign buf_free  = (buf_cnt_q == '0) || (take && head_last);
	assign xfer      = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !buf_free;
	assign in_take   = in_valid && !in_stall;

	assign out_valid   = buf_cnt_q != '0;
	assign event_kind  = buf_kind_q[buf_idx_q];
	assign char_out    = buf_chr_q[buf_idx_q];
	assign last_of_run = head_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (xfer) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= char_in;
			last_s1 <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			buf_cnt_q <= '0;
			buf_idx_q <= '0;
		end else begin
			if (xfer) begin
				state_q <= res.nxt;
			end
			if (buf_free) begin
				buf_idx_q <= '0;
				buf_cnt_q <= xfer ? res.cnt : '0;
			end else if (take) begin
				buf_idx_q <= buf_idx_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			buf_kind_q <= res.kind;
			buf_chr_q  <= res.chr;
		end
	end

`ifndef SYNTHESIS
	// head always points inside the loaded events
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, buf_idx_q} < buf_cnt_q))
		else $error("event buffer head beyond fill");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		buf_cnt_q <= CntW'(MaxEvents))
		else $error("event buffer overfilled");

	// the final byte of a document leaves the lexer in its reset state
	a_doc_end: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && last_s1 |=> state_q == '0)
		else $error("lexer flags not cleared after final byte");

	// an empty input stage never stalls
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty stage");
`endif

endmodule
